// ----- src/log2_power_of_two_quantizer_defines.svh -----
// Assertion macros used by the quantizer top level.
// No dependencies.
`ifndef LOG2_POWER_OF_TWO_QUANTIZER_DEFINES_SVH
`define LOG2_POWER_OF_TWO_QUANTIZER_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define LPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/lpq_pkg.sv -----
// Shared types and constants for the log2 power-of-two quantizer.
// No dependencies.
package lpq_pkg;
  localparam logic [22:0] SQRT2_FRAC = 23'h3504F4;
  localparam logic [31:0] POS_INF = 32'h7F800000;
  localparam logic [0:0] CFG_EXP_BIAS = 1'b0;
  localparam logic [0:0] CFG_CODE_WIDTH = 1'b1;

  // Stage 1 to stage 2: classified input and raw level.
  typedef struct packed {
    logic              neg;
    logic              is_nan;
    logic              is_inf;
    logic signed [9:0] level;
  } lvl_t;

  // Stage 2 to stage 3: biased exponent.
  typedef struct packed {
    logic              neg;
    logic signed [9:0] p;
  } pexp_t;
endpackage

// ----- src/lpq_level.sv -----
// Stage 1: classifies the float and finds the rounded log2 level.
// Depends on lpq_pkg.
module lpq_level (
  input  logic [31:0]   value_bits,
  output lpq_pkg::lvl_t lvl
);
  logic [7:0]  e;
  logic [22:0] f;
  logic [23:0] m;
  logic [4:0]  top;
  logic [23:0] norm;

  assign e = value_bits[30:23];
  assign f = value_bits[22:0];
  assign m = {1'b0, f} + 24'd1;

  // Leading-one position of the denormal mantissa plus one ulp.
  always_comb begin
    top = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) top = 5'(i);
    end
    norm = m << (5'd23 - top);
  end

  // Level selection per class.
  always_comb begin
    lvl.is_nan = (e == 8'hFF) && (f != 23'd0);
    lvl.is_inf = (e == 8'hFF) && (f == 23'd0);
    lvl.neg    = lvl.is_nan ? 1'b1 : ((e == 8'd0 && f == 23'd0) ? 1'b0 : value_bits[31]);
    if (e == 8'd0 && f == 23'd0) begin
      lvl.level = -10'sd149;
    end else if (e == 8'd0) begin
      lvl.level = $signed({5'd0, top}) - 10'sd149
                  + ((norm[22:0] >= lpq_pkg::SQRT2_FRAC) ? 10'sd1 : 10'sd0);
    end else begin
      lvl.level = $signed({2'd0, e}) - 10'sd127
                  + ((f >= lpq_pkg::SQRT2_FRAC) ? 10'sd1 : 10'sd0);
    end
  end
endmodule

// ----- src/lpq_clip.sv -----
// Stage 2: clips the level to the code range and subtracts the bias.
// Depends on lpq_pkg.
module lpq_clip (
  input  lpq_pkg::lvl_t  lvl,
  input  logic [3:0]     code_width,
  input  logic [7:0]     exp_bias,
  output lpq_pkg::pexp_t pe
);
  logic [3:0]        w;
  logic signed [9:0] hi;
  logic signed [9:0] lo;
  logic signed [9:0] lev;

  always_comb begin
    w  = (code_width == 4'd0) ? 4'd1 : ((code_width > 4'd8) ? 4'd8 : code_width);
    hi = $signed(10'(10'd1 << (w - 4'd1))) - 10'sd1;
    lo = -$signed(10'(10'd1 << (w - 4'd1)));
    if (lvl.is_nan) lev = lo;
    else if (lvl.is_inf) lev = hi;
    else if (lvl.level < lo) lev = lo;
    else if (lvl.level > hi) lev = hi;
    else lev = lvl.level;
    pe.neg = lvl.neg;
    pe.p   = lev - {{2{exp_bias[7]}}, exp_bias};
  end
endmodule

// ----- src/log2_power_of_two_quantizer.sv -----
// Top level of the log2 power-of-two quantizer: three-stage pipeline.
// Depends on lpq_pkg, lpq_level, lpq_clip and the defines header.
//
// Usage: one IEEE-754 single enters on in_value_bits with in_valid/in_ready;
// one result leaves on out_* with out_valid/out_ready per input transfer.
// Three register stages (level, clip/bias, output encode) lie between the
// input transfer and out_valid. Throughput is one item per cycle, each
// stage advancing whenever the stage ahead is free.
// cfg_valid/cfg_ready write exp_bias (index 0) or code_width (index 1);
// cfg_ready is always high, and writes belong only in idle periods.
// Reset (synchronous, active low) empties the pipeline and loads
// exp_bias = 0, code_width = 8. When the receiver stalls, the stages fill
// and in_ready falls once the first stage cannot move; nothing is lost.
`include "log2_power_of_two_quantizer_defines.svh"
module log2_power_of_two_quantizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_neg_sign,
  output logic [8:0]  out_pow_exponent,
  output logic [31:0] out_quant_bits,
  output logic        out_out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  logic [7:0] exp_bias_r;
  logic [3:0] code_width_r;
  logic       v1_r, v2_r, v3_r;
  logic       adv1, adv2, adv3;
  lpq_pkg::lvl_t  lvl_c, lvl_r;
  lpq_pkg::pexp_t pe_c, pe_r;
  logic [31:0] q_nxt;
  logic        oor_nxt;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bias_r   <= 8'd0;
      code_width_r <= 4'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        lpq_pkg::CFG_EXP_BIAS:   exp_bias_r   <= cfg_data;
        lpq_pkg::CFG_CODE_WIDTH: code_width_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Stall chain: a stage moves when the next one is empty or moving.
  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  lpq_level u_level (.value_bits(in_value_bits), .lvl(lvl_c));
  lpq_clip  u_clip  (.lvl(lvl_r), .code_width(code_width_r), .exp_bias(exp_bias_r),
                     .pe(pe_c));

  // Output encode from the biased exponent.
  always_comb begin
    oor_nxt = (pe_r.p < -10'sd126) || (pe_r.p > 10'sd127);
    if (pe_r.p < -10'sd126) q_nxt = {pe_r.neg, 31'd0};
    else if (pe_r.p > 10'sd127) q_nxt = {pe_r.neg, 31'd0} | lpq_pkg::POS_INF;
    else q_nxt = {pe_r.neg, 8'(pe_r.p + 10'sd127), 23'd0};
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv1) lvl_r <= lvl_c;
    if (adv2) pe_r <= pe_c;
    if (adv3) begin
      out_neg_sign     <= pe_r.neg;
      out_pow_exponent <= pe_r.p[8:0];
      out_quant_bits   <= q_nxt;
      out_out_of_range <= oor_nxt;
    end
  end

  assign out_valid = v3_r;

  `LPQ_ASSERT_NXT(a_hold, clk, rst_n, v3_r && !out_ready, v3_r)
  `LPQ_ASSERT_IMP(a_ready, clk, rst_n, !v1_r && !v2_r && !v3_r, in_ready)
  `LPQ_ASSERT_IMP(a_oor_q, clk, rst_n, v3_r && !out_out_of_range,
                  out_quant_bits[30:23] != 8'hFF && out_quant_bits[30:23] != 8'h00)
endmodule
